[sv/tcw_pkg.sv]
package tcw_pkg;

  // Default screen geometry
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Fixed field widths
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 4;
  localparam int IN_ATTR_W = 8;
  localparam int CURSOR_W = 11;
  localparam int INDEX_W  = 11;

  // Character codes with special handling, plus the blank cell's character and attribute
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [ATTR_W-1:0] PLAIN_ATTR   = 4'h7;

  // Item opcodes
  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Spaces written for one tab
  localparam logic [3:0] TAB_SPACES = 4'd8;

  typedef struct packed {
    logic [ATTR_W-1:0] attr;
    logic [CHAR_W-1:0] ch;
  } cell_t;

  localparam cell_t BLANK_CELL = '{attr: PLAIN_ATTR, ch: BLANK_CHAR};

endpackage

[sv/tcw_screen_mem.sv]
module tcw_screen_mem #(
  parameter int DEPTH = 2000,
  parameter int AW    = 11
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  tcw_pkg::cell_t  wdata,
  input  logic [AW-1:0]   raddr,
  output tcw_pkg::cell_t  rdata
);
  import tcw_pkg::*;

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/tcw_ctrl.sv]
module tcw_ctrl #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  parameter int AW      = 11
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           op,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code,
  input  logic [tcw_pkg::IN_ATTR_W-1:0]  attribute,
  input  logic [tcw_pkg::INDEX_W-1:0]    cell_index,
  output logic                           done,
  output logic [tcw_pkg::CURSOR_W-1:0]   cursor_position,
  output logic [tcw_pkg::CHAR_W-1:0]     cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]     cell_attr,
  output logic                           scrolled,
  output logic                           mem_we,
  output logic [AW-1:0]                  mem_waddr,
  output tcw_pkg::cell_t                 mem_wdata,
  output logic [AW-1:0]                  mem_raddr,
  input  tcw_pkg::cell_t                 mem_rdata
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;
  localparam int CW    = $clog2(CELLS + COLUMNS);
  localparam int COLW  = $clog2(COLUMNS);

  localparam logic [CW-1:0]   CELLS_C   = CW'(CELLS);
  localparam logic [CW-1:0]   COLS_CUR  = CW'(COLUMNS);
  localparam logic [AW-1:0]   COLS_ADDR = AW'(COLUMNS);
  localparam logic [AW-1:0]   LAST_ADDR = AW'(CELLS - 1);
  localparam logic [AW-1:0]   ROW_LAST  = AW'(CELLS - COLUMNS);
  localparam logic [COLW-1:0] COL_LAST  = COLW'(COLUMNS - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD_WAIT, S_EXEC, S_PLAIN, S_BS_RD, S_BS_WR,
    S_CHECK, S_SC_COPY, S_SC_BLANK, S_SC_DRAIN, S_STEP_END
  } state_t;

  state_t            state;
  logic [CW-1:0]     cursor;
  logic [COLW-1:0]   col;
  logic [AW-1:0]     sa;
  logic [3:0]        tab_left;
  logic [CHAR_W-1:0] ch_l;
  logic [ATTR_W-1:0] attr_l;
  logic              rd_ok;
  logic              scr;
  logic              pw_valid;
  logic [AW-1:0]     pw_addr;
  logic              pw_blank;

  assign busy = (state != S_IDLE);

  // Memory port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(cursor);
    mem_wdata = BLANK_CELL;
    mem_raddr = AW'(cursor);
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sa;
      end
      S_IDLE: begin
        mem_raddr = AW'(cell_index);
      end
      S_PLAIN: begin
        mem_we    = 1'b1;
        mem_wdata = '{attr: attr_l, ch: ch_l};
      end
      S_BS_WR: begin
        mem_we    = 1'b1;
        mem_wdata = '{attr: mem_rdata.attr, ch: BLANK_CHAR};
      end
      S_SC_COPY, S_SC_BLANK, S_SC_DRAIN: begin
        mem_raddr = sa;
        mem_we    = pw_valid;
        mem_waddr = pw_addr;
        mem_wdata = pw_blank ? cell_t'{attr: mem_rdata.attr, ch: BLANK_CHAR} : mem_rdata;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cursor   <= '0;
      col      <= '0;
      sa       <= '0;
      pw_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          sa <= sa + AW'(1);
          if (sa == LAST_ADDR) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            ch_l     <= char_code;
            attr_l   <= attribute[ATTR_W-1:0];
            rd_ok    <= (int'(cell_index) < CELLS);
            scr      <= 1'b0;
            tab_left <= 4'd1;
            state    <= (op == OP_READ) ? S_RD_WAIT : S_EXEC;
          end
        end
        S_RD_WAIT: begin
          done            <= 1'b1;
          cursor_position <= CURSOR_W'(cursor);
          cell_char       <= rd_ok ? mem_rdata.ch : '0;
          cell_attr       <= rd_ok ? mem_rdata.attr : '0;
          scrolled        <= 1'b0;
          state           <= S_IDLE;
        end
        S_EXEC: begin
          case (ch_l)
            CH_NEWLINE: begin
              cursor <= cursor - CW'(col) + COLS_CUR;
              col    <= '0;
              state  <= S_CHECK;
            end
            CH_RETURN: begin
              cursor <= cursor - CW'(col);
              col    <= '0;
              state  <= S_CHECK;
            end
            CH_TAB: begin
              ch_l     <= BLANK_CHAR;
              attr_l   <= PLAIN_ATTR;
              tab_left <= TAB_SPACES;
              state    <= S_PLAIN;
            end
            CH_BACKSPACE: begin
              if (cursor != '0) begin
                cursor <= cursor - CW'(1);
                col    <= (col == '0) ? COL_LAST : col - COLW'(1);
              end
              state <= S_BS_RD;
            end
            default: begin
              state <= S_PLAIN;
            end
          endcase
        end
        S_PLAIN: begin
          cursor <= cursor + CW'(1);
          col    <= (col == COL_LAST) ? '0 : col + COLW'(1);
          state  <= S_CHECK;
        end
        S_BS_RD: begin
          state <= S_BS_WR;
        end
        S_BS_WR: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (cursor >= CELLS_C) begin
            scr   <= 1'b1;
            sa    <= COLS_ADDR;
            state <= S_SC_COPY;
          end else begin
            state <= S_STEP_END;
          end
        end
        S_SC_COPY: begin
          // move cell sa up one row; the write lands in the next cycle
          pw_valid <= 1'b1;
          pw_addr  <= sa - COLS_ADDR;
          pw_blank <= 1'b0;
          if (sa == LAST_ADDR) begin
            sa    <= ROW_LAST;
            state <= S_SC_BLANK;
          end else begin
            sa <= sa + AW'(1);
          end
        end
        S_SC_BLANK: begin
          pw_valid <= 1'b1;
          pw_addr  <= sa;
          pw_blank <= 1'b1;
          if (sa == LAST_ADDR) begin
            state <= S_SC_DRAIN;
          end else begin
            sa <= sa + AW'(1);
          end
        end
        S_SC_DRAIN: begin
          pw_valid <= 1'b0;
          cursor   <= cursor - COLS_CUR;
          state    <= S_STEP_END;
        end
        S_STEP_END: begin
          if (tab_left > 4'd1) begin
            tab_left <= tab_left - 4'd1;
            state    <= S_PLAIN;
          end else begin
            done            <= 1'b1;
            cursor_position <= CURSOR_W'(cursor);
            cell_char       <= '0;
            cell_attr       <= '0;
            scrolled        <= scr;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_idle_cursor: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (cursor < CELLS_C))
    else $error("cursor left on screen overflow while idle");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  a_done_drained: assert property (@(posedge clk) disable iff (rst)
    done |-> !pw_valid)
    else $error("result issued with a scroll write still pending");

endmodule

[sv/text_console_char_writer.sv]
// Text console writer over a COLUMNS x ROWS screen held in one synchronous
// memory (12-bit cells: attribute in the top four bits, character below).
// Issue a transaction by raising start while busy is low; exactly one result
// follows, shown for a single cycle with done high. The receiver cannot stall,
// so capture the result ports whenever done is high. After reset the block
// fills the screen with spaces of attribute 7 and holds busy high meanwhile.
// Each transaction runs to its result before the next can be accepted, and
// the single memory port pair sets the read-then-write sequencing: a cell
// read is one registered memory read; backspace reads, then writes back the
// blanked cell; a tab makes eight space writes. A put that runs the cursor
// past the last cell adds a scroll: every cell below the top row is read
// once and written back one row up, then the last row is blanked with its
// attributes kept. A new transaction may be accepted in the same cycle that
// done is shown.
module text_console_char_writer #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          op,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
  input  logic [tcw_pkg::IN_ATTR_W-1:0] attribute,
  input  logic [tcw_pkg::INDEX_W-1:0]   cell_index,
  output logic                          done,
  output logic [tcw_pkg::CURSOR_W-1:0]  cursor_position,
  output logic [tcw_pkg::CHAR_W-1:0]    cell_char,
  output logic [tcw_pkg::ATTR_W-1:0]    cell_attr,
  output logic                          scrolled
);
  import tcw_pkg::*;

  // Screen geometry
  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);

  // Memory port wires between the sequencer and the screen store
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  cell_t         mem_wdata;
  logic [AW-1:0] mem_raddr;
  cell_t         mem_rdata;

  // Screen store: one write and one registered read per cycle
  tcw_screen_mem #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer: cursor, control codes, scroll sweep, clearing pass
  tcw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .char_code       (char_code),
    .attribute       (attribute),
    .cell_index      (cell_index),
    .done            (done),
    .cursor_position (cursor_position),
    .cell_char       (cell_char),
    .cell_attr       (cell_attr),
    .scrolled        (scrolled),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

endmodule

[tb/text_console_screen_checker.sv]
`timescale 1ns / 100ps

module text_console_screen_checker #(
  parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          op,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
  input  logic [tcw_pkg::IN_ATTR_W-1:0] attribute,
  input  logic [tcw_pkg::INDEX_W-1:0]   cell_index,
  input  logic                          done,
  input  logic [tcw_pkg::CURSOR_W-1:0]  cursor_position,
  input  logic [tcw_pkg::CHAR_W-1:0]    cell_char,
  input  logic [tcw_pkg::ATTR_W-1:0]    cell_attr,
  input  logic                          scrolled,
  output int                            mismatches,
  output int                            outstanding
);
  import tcw_pkg::*;

  localparam int CELLS = COLUMNS * ROWS;

  typedef struct packed {
    logic [CURSOR_W-1:0] cursor;
    logic [CHAR_W-1:0]   ch;
    logic [ATTR_W-1:0]   attr;
    logic                rolled;
  } console_result_t;

  cell_t           screen_image [CELLS];
  int unsigned     cursor_at;
  console_result_t predicted_results [$];
  console_result_t seen;
  console_result_t want;
  int              mismatch_tally;

  // Scroll up one row once the cursor has run off the end of the screen.
  function automatic bit roll_screen_up();
    int i;
    if (cursor_at < CELLS) return 1'b0;
    for (i = 0; i < CELLS - COLUMNS; i++) screen_image[i] = screen_image[i + COLUMNS];
    for (i = CELLS - COLUMNS; i < CELLS; i++) screen_image[i].ch = BLANK_CHAR;
    cursor_at -= COLUMNS;
    return 1'b1;
  endfunction

  function automatic bit store_glyph(logic [CHAR_W-1:0] ch, logic [ATTR_W-1:0] attr);
    if (cursor_at < CELLS) screen_image[cursor_at] = '{attr: attr, ch: ch};
    cursor_at++;
    return roll_screen_up();
  endfunction

  // Apply one put to the screen image; report whether it scrolled.
  function automatic bit apply_put(logic [CHAR_W-1:0] ch, logic [IN_ATTR_W-1:0] attr);
    bit rolled;
    int k;
    rolled = 1'b0;
    case (ch)
      CH_NEWLINE: begin
        cursor_at += COLUMNS;
        cursor_at -= cursor_at % COLUMNS;
        rolled = roll_screen_up();
      end
      CH_RETURN: begin
        cursor_at -= cursor_at % COLUMNS;
        rolled = roll_screen_up();
      end
      CH_TAB: begin
        for (k = 0; k < TAB_SPACES; k++)
          if (store_glyph(BLANK_CHAR, PLAIN_ATTR)) rolled = 1'b1;
      end
      CH_BACKSPACE: begin
        if (cursor_at > 0) cursor_at--;
        if (cursor_at < CELLS) screen_image[cursor_at].ch = BLANK_CHAR;
        rolled = roll_screen_up();
      end
      default: rolled = store_glyph(ch, attr[ATTR_W-1:0]);
    endcase
    return rolled;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (screen_image[i]) screen_image[i] = BLANK_CELL;
      cursor_at = 0;
      predicted_results.delete();
      mismatch_tally = 0;
    end else begin
      // Retire the oldest prediction against the result shown this cycle.
      if (done) begin
        seen = '{cursor: cursor_position, ch: cell_char, attr: cell_attr, rolled: scrolled};
        if (predicted_results.size() == 0) begin
          mismatch_tally++;
          if (mismatch_tally <= 10)
            $display("%0t: unexpected result cursor=%0d char=%h attr=%h scrolled=%b",
                     $realtime, seen.cursor, seen.ch, seen.attr, seen.rolled);
        end else begin
          want = predicted_results.pop_front();
          if (seen !== want) begin
            mismatch_tally++;
            if (mismatch_tally <= 10)
              $display("%0t: exp/act cursor %0d/%0d char %h/%h attr %h/%h scrolled %b/%b",
                       $realtime, want.cursor, seen.cursor, want.ch, seen.ch,
                       want.attr, seen.attr, want.rolled, seen.rolled);
          end
        end
      end
      // Predict the transaction accepted at this edge.
      if (start && !busy) begin
        want = '0;
        if (op == OP_PUT) begin
          want.rolled = apply_put(char_code, attribute);
        end else if (cell_index < CELLS) begin
          want.ch   = screen_image[cell_index].ch;
          want.attr = screen_image[cell_index].attr;
        end
        want.cursor = cursor_at[CURSOR_W-1:0];
        predicted_results.push_back(want);
      end
    end
    outstanding <= predicted_results.size();
    mismatches  <= mismatch_tally;
  end

endmodule

[tb/tb_text_console_char_writer.sv]
`timescale 1ns / 100ps

module tb_text_console_char_writer;
  import tcw_pkg::*;

  // Cycles without any accepted transaction or result before giving up. The
  // slowest legal gap is a scroll plus a tab, plus the clearing pass after
  // reset, plus the final settle wait.
  localparam int WATCHDOG_LIMIT = 12000;
  localparam int SETTLE_CYCLES  = 2100;
  localparam int ITEM_TARGET    = 600;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 op = OP_PUT;
  logic [CHAR_W-1:0]    char_code = '0;
  logic [IN_ATTR_W-1:0] attribute = '0;
  logic [INDEX_W-1:0]   cell_index = '0;
  logic                 done;
  logic [CURSOR_W-1:0]  cursor_position;
  logic [CHAR_W-1:0]    cell_char;
  logic [ATTR_W-1:0]    cell_attr;
  logic                 scrolled;

  int                   mismatches;
  int                   outstanding;
  int                   idle_pct = 9;
  int                   items_sent = 0;
  int                   quiet_cycles = 0;
  logic [CURSOR_W-1:0]  last_cursor = '0;

  always #2 clk = ~clk;

  text_console_char_writer dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .char_code       (char_code),
    .attribute       (attribute),
    .cell_index      (cell_index),
    .done            (done),
    .cursor_position (cursor_position),
    .cell_char       (cell_char),
    .cell_attr       (cell_attr),
    .scrolled        (scrolled)
  );

  text_console_screen_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .char_code       (char_code),
    .attribute       (attribute),
    .cell_index      (cell_index),
    .done            (done),
    .cursor_position (cursor_position),
    .cell_char       (cell_char),
    .cell_attr       (cell_attr),
    .scrolled        (scrolled),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  // Track the last reported cursor so reads can aim at recently written cells.
  always @(posedge clk) begin
    if (done) last_cursor <= cursor_position;
  end

  // Watchdog: reset the count on any accepted transaction or result.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one transaction and hold it until accepted. Start stays high after
  // acceptance so the next transaction can follow back to back; it only drops
  // when the sender decides to idle.
  task automatic send_item(input logic o, input logic [CHAR_W-1:0] c,
                           input logic [IN_ATTR_W-1:0] a, input logic [INDEX_W-1:0] idx);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    op         <= o;
    char_code  <= c;
    attribute  <= a;
    cell_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // Put a character; the ignored index gets random bits.
  task automatic put_glyph(input logic [CHAR_W-1:0] c, input logic [IN_ATTR_W-1:0] a);
    send_item(OP_PUT, c, a, INDEX_W'($urandom_range(0, 2047)));
  endtask

  // Read a cell; the ignored character and attribute get random bits.
  task automatic read_cell(input logic [INDEX_W-1:0] idx);
    send_item(OP_READ, CHAR_W'($urandom_range(0, 255)),
              IN_ATTR_W'($urandom_range(0, 255)), idx);
  endtask

  // Drop start and hold off until every predicted result has come back.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int pick;
    int line_len;
    int n;
    int tail;
    int near;
    logic [IN_ATTR_W-1:0] line_attr;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part: reset contents, out-of-range reads, backspace at cell
    // zero, field extremes and every control code.
    read_cell(0);
    read_cell(1999);
    read_cell(2000);
    read_cell(2047);
    put_glyph(CH_BACKSPACE, 8'hFF);
    read_cell(0);
    put_glyph(8'h41, 8'hFF);
    put_glyph(8'h00, 8'h00);
    put_glyph(8'hFF, 8'hA5);
    put_glyph(CH_BACKSPACE, 8'h00);
    read_cell(2);
    put_glyph(CH_TAB, 8'hFF);
    read_cell(5);
    put_glyph(8'h7F, 8'hF0);
    put_glyph(CH_RETURN, 8'h3C);
    put_glyph(CH_NEWLINE, 8'hC3);
    put_glyph(CH_BACKSPACE, 8'h11);
    read_cell(0);
    read_cell(1);
    read_cell(79);
    drain_results();

    // Random part: mostly text lines ending in newlines, so the cursor walks
    // down the screen and keeps scrolling; reads aimed near the cursor check
    // what was written and what moved; noise covers every field value.
    while (items_sent < ITEM_TARGET) begin
      // Switch sender behavior by thirds, pausing for a full drain at each step.
      if (idle_pct == 9 && items_sent >= ITEM_TARGET / 3) begin
        drain_results();
        idle_pct = 66;
      end else if (idle_pct == 66 && items_sent >= 2 * ITEM_TARGET / 3) begin
        drain_results();
        idle_pct = 0;
      end

      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // A long line wraps a row, and a trailing tab can scroll on its own.
        line_len  = ($urandom_range(0, 11) == 0) ? $urandom_range(72, 85) : $urandom_range(0, 12);
        line_attr = IN_ATTR_W'($urandom_range(0, 255));
        for (n = 0; n < line_len; n++) begin
          if ($urandom_range(0, 14) == 0)
            put_glyph(CH_BACKSPACE, line_attr);
          else if ($urandom_range(0, 19) == 0)
            put_glyph(CHAR_W'($urandom_range(0, 255)), IN_ATTR_W'($urandom_range(0, 255)));
          else
            put_glyph(CHAR_W'($urandom_range(32, 126)), line_attr);
        end
        tail = $urandom_range(0, 9);
        if (line_len > 70 && tail < 5) begin
          put_glyph(CH_TAB, line_attr);
        end else if (tail < 2) begin
          put_glyph(CH_RETURN, line_attr);
          put_glyph(CH_NEWLINE, line_attr);
        end else if (tail < 8) begin
          put_glyph(CH_NEWLINE, line_attr);
        end
      end else if (pick < 80) begin
        for (n = $urandom_range(1, 4); n > 0; n--) begin
          if ($urandom_range(0, 1) == 0) begin
            near = int'(last_cursor) - int'($urandom_range(0, 160));
            if (near < 0) near = 0;
            read_cell(INDEX_W'(near));
          end else begin
            read_cell(INDEX_W'($urandom_range(0, 2047)));
          end
        end
      end else begin
        send_item(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                  IN_ATTR_W'($urandom_range(0, 255)), INDEX_W'($urandom_range(0, 2047)));
      end
    end

    // Drain, then give a stray result time to show up.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[sim.f]
sv/tcw_pkg.sv
sv/tcw_screen_mem.sv
sv/tcw_ctrl.sv
sv/text_console_char_writer.sv
tb/text_console_screen_checker.sv
tb/tb_text_console_char_writer.sv
